// ----- rtl/shs_pkg.sv -----
package shs_pkg;

  // Hash selector codes
  typedef enum logic [3:0] {
    ALG_RS   = 4'd0,
    ALG_JS   = 4'd1,
    ALG_PJW  = 4'd2,
    ALG_ELF  = 4'd3,
    ALG_BKDR = 4'd4,
    ALG_SDBM = 4'd5,
    ALG_DJB  = 4'd6,
    ALG_DEK  = 4'd7,
    ALG_AP   = 4'd8,
    ALG_CRC  = 4'd9
  } alg_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALG_SELECT   = 2'd0;
  localparam logic [1:0] CFG_BYTE_SIGNED  = 2'd1;
  localparam logic [1:0] CFG_BKDR_MULT    = 2'd2;

  localparam logic [31:0] RS_B        = 32'd378551;
  localparam logic [31:0] RS_A0       = 32'd63689;
  localparam logic [31:0] JS_INIT     = 32'd1315423911;
  localparam logic [31:0] HIGH_NIBBLE = 32'hF000_0000;
  localparam logic [31:0] BKDR_INIT   = 32'd131;
  localparam logic [31:0] DJB_INIT    = 32'd5381;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] LOW31       = 32'h7FFF_FFFF;

  // Configuration register set
  typedef struct packed {
    alg_t        alg;
    logic        byte_signed;
    logic [31:0] bkdr_mult;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        first;
    logic        last;
    logic        empty;
    logic [30:0] msg_len;
  } item_t;

  // Running state
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] rs_mult;
    logic        odd;
  } hstate_t;

  // Reflected CRC-32 table entry; elaborates to a 256-entry constant ROM
  function automatic logic [31:0] crc_rom(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/multi_algorithm_string_hash.sv -----
// Channel | Direction | Handshake          | Word
// in_     | input     | in_valid/in_stall  | byte, first/last/empty flags, length
// out_    | output    | out_valid/out_stall| 32-bit finished hash
// cfg_    | input     | cfg_valid/cfg_ready| register index, 32-bit data
//
// One byte per cycle while neither in_stall nor out_stall holds the flow; a word is held in the
// input register and its hash is loaded from there into the output register.
// The loop is the running-hash update: one 32x32 multiply plus an add.
// rst_n is synchronous, active low; clears state and restores config defaults.
// in_stall rises only while a finishing word waits behind a stalled output.
// cfg_ready is always high.
module multi_algorithm_string_hash
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_first_of_message,
  input  logic        in_last_of_message,
  input  logic        in_empty_message,
  input  logic [30:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_valid_r;
  hstate_t state_r;
  hstate_t state_nxt;
  logic    emit;
  logic    fire;
  logic    can_load;
  logic [31:0] result;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alg         <= ALG_RS;
      cfg_r.byte_signed <= 1'b1;
      cfg_r.bkdr_mult   <= BKDR_INIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALG_SELECT:  cfg_r.alg         <= alg_t'(cfg_wdata[3:0]);
        CFG_BYTE_SIGNED: cfg_r.byte_signed <= cfg_wdata[0];
        CFG_BKDR_MULT:   cfg_r.bkdr_mult   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Held word moves on unless it finishes into a blocked output
  assign fire     = item_valid_r && (!emit || can_load);
  assign in_stall = item_valid_r && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.byte_value <= in_byte_value;
      item_r.first      <= in_first_of_message;
      item_r.last       <= in_last_of_message;
      item_r.empty      <= in_empty_message;
      item_r.msg_len    <= in_message_length;
    end
  end

  // Hash update
  shs_absorb u_absorb (
    .cfg    (cfg_r),
    .item   (item_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.hash    <= 32'd0;
      state_r.rs_mult <= RS_A0;
      state_r.odd     <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  shs_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (fire && emit),
    .load_value     (result),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

// ----- rtl/shs_absorb.sv -----
module shs_absorb
  import shs_pkg::*;
(
  input  cfg_t        cfg,
  input  item_t       item,
  input  hstate_t     cur,
  output hstate_t     nxt,
  output logic        emit,
  output logic [31:0] result
);

  logic [31:0] ch;
  logic [31:0] init_hash;
  logic [31:0] h0;
  logic [31:0] rs0;
  logic        odd0;
  logic [31:0] mult_sel;
  logic [31:0] prod;
  logic [31:0] nib;
  logic [31:0] nib_top;
  logic [31:0] h_new;

  // Byte extension
  assign ch = (cfg.byte_signed && item.byte_value[7]) ? {24'hFF_FFFF, item.byte_value}
                                                       : {24'd0, item.byte_value};

  // Initial value; empty message seeds DEK with zero
  always_comb begin
    case (cfg.alg)
      ALG_JS:  init_hash = JS_INIT;
      ALG_DJB: init_hash = DJB_INIT;
      ALG_DEK: init_hash = item.empty ? 32'd0 : {1'b0, item.msg_len};
      ALG_CRC: init_hash = ALL_ONES;
      default: init_hash = 32'd0;
    endcase
  end

  assign h0   = (item.first || item.empty) ? init_hash : cur.hash;
  assign rs0  = (item.first || item.empty) ? RS_A0     : cur.rs_mult;
  assign odd0 = (item.first || item.empty) ? 1'b0      : cur.odd;

  // Shared multiplier for RS and BKDR
  assign mult_sel = (cfg.alg == ALG_RS) ? rs0 : cfg.bkdr_mult;
  assign prod     = h0 * mult_sel;

  // PJW / ELF folding
  assign nib     = (h0 << 4) + ch;
  assign nib_top = nib & HIGH_NIBBLE;

  always_comb begin
    case (cfg.alg)
      ALG_RS:   h_new = prod + ch;
      ALG_JS:   h_new = h0 ^ ((h0 << 5) + ch + (h0 >> 2));
      ALG_PJW,
      ALG_ELF:  h_new = (nib_top != 32'd0) ? ((nib ^ (nib_top >> 24)) & ~HIGH_NIBBLE) : nib;
      ALG_BKDR: h_new = prod + ch;
      ALG_SDBM: h_new = ch + (h0 << 6) + (h0 << 16) - h0;
      ALG_DJB:  h_new = (h0 << 5) + h0 + ch;
      ALG_DEK:  h_new = ((h0 << 5) ^ (h0 >> 27)) ^ ch;
      ALG_AP:   h_new = odd0 ? (h0 ^ ~((h0 << 11) ^ ch ^ (h0 >> 5)))
                             : (h0 ^ ((h0 << 7) ^ ch ^ (h0 >> 3)));
      ALG_CRC:  h_new = (h0 >> 8) ^ crc_rom(h0[7:0] ^ ch[7:0]);
      default:  h_new = h0;
    endcase
  end

  // Next state: empty message only loads the initial value
  always_comb begin
    if (item.empty) begin
      nxt.hash    = h0;
      nxt.rs_mult = rs0;
      nxt.odd     = odd0;
    end else begin
      nxt.hash    = h_new;
      nxt.rs_mult = rs0 * RS_B;
      nxt.odd     = ~odd0;
    end
  end

  // Finished hash
  assign emit   = item.empty || item.last;
  assign result = (cfg.alg == ALG_CRC) ? ~nxt.hash : (nxt.hash & LOW31);

endmodule

// ----- rtl/shs_out_reg.sv -----
module shs_out_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [31:0] load_value,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] value_r;

  // Free when empty or the held word leaves this cycle
  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= load_value;
    end
  end

  assign out_valid      = valid_r;
  assign out_hash_value = value_r;

endmodule

// ----- tb/string_hash_checker.sv -----
// Watches the three channels of the string hash block, keeps its own copy of
// the hash state and configuration, and compares every finished hash word.
module string_hash_checker
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_first_of_message,
  input  logic        in_last_of_message,
  input  logic        in_empty_message,
  input  logic [30:0] in_message_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatch_count,
  output int          hashes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow configuration
  logic [3:0]  sel;
  logic        sign_ext;
  logic [31:0] bkdr_mult;

  // Shadow running state
  logic [31:0] run_hash;
  logic [31:0] rs_mult;
  logic        odd_byte;

  // Finished hashes not yet seen on the result channel
  logic [31:0] expected_hashes[$];

  // Reflected CRC-32 table entry, built bit by bit
  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] r;
    r = {24'd0, idx};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction

  // Start of message: per-algorithm initial value
  function automatic void seed_state(input logic [30:0] len);
    rs_mult  = RS_A0;
    odd_byte = 1'b0;
    case (sel)
      ALG_JS:  run_hash = JS_INIT;
      ALG_DJB: run_hash = DJB_INIT;
      ALG_DEK: run_hash = {1'b0, len};
      ALG_CRC: run_hash = ALL_ONES;
      default: run_hash = 32'd0;
    endcase
  endfunction

  // Fold one message byte into the running hash
  function automatic void mix_byte(input logic [7:0] b);
    logic [31:0] h;
    logic [31:0] ch;
    logic [31:0] nib;
    h  = run_hash;
    ch = {{24{sign_ext & b[7]}}, b};
    case (sel)
      ALG_RS:   h = h * rs_mult + ch;
      ALG_JS:   h = h ^ ((h << 5) + ch + (h >> 2));
      ALG_PJW, ALG_ELF: begin
        h   = (h << 4) + ch;
        nib = h & HIGH_NIBBLE;
        if (nib != 32'd0) h = (h ^ (nib >> 24)) & ~HIGH_NIBBLE;
      end
      ALG_BKDR: h = h * bkdr_mult + ch;
      ALG_SDBM: h = ch + (h << 6) + (h << 16) - h;
      ALG_DJB:  h = (h << 5) + h + ch;
      ALG_DEK:  h = ((h << 5) ^ (h >> 27)) ^ ch;
      ALG_AP: begin
        if (odd_byte) h = h ^ ~((h << 11) ^ ch ^ (h >> 5));
        else          h = h ^ ((h << 7) ^ ch ^ (h >> 3));
      end
      ALG_CRC:  h = (h >> 8) ^ crc_entry(h[7:0] ^ ch[7:0]);
      default:  ;  // unused selector: hash holds
    endcase
    run_hash = h;
    rs_mult  = rs_mult * RS_B;
    odd_byte = ~odd_byte;
  endfunction

  // Output form: CRC inverted, the rest with bit 31 cleared
  function automatic logic [31:0] finished_hash();
    if (sel == ALG_CRC) return run_hash ^ ALL_ONES;
    return run_hash & LOW31;
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      sel            = ALG_RS;
      sign_ext       = 1'b1;
      bkdr_mult      = BKDR_INIT;
      run_hash       = 32'd0;
      rs_mult        = RS_A0;
      odd_byte       = 1'b0;
      mismatch_count = 0;
      expected_hashes.delete();
    end else begin
      // result word against oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: hash_value expected none, got %h", $time, out_hash_value);
          mismatch_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_hash_value !== want) begin
            $display("%0t: hash_value expected %h, got %h", $time, want, out_hash_value);
            mismatch_count++;
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALG_SELECT:  sel       = cfg_wdata[3:0];
          CFG_BYTE_SIGNED: sign_ext  = cfg_wdata[0];
          CFG_BKDR_MULT:   bkdr_mult = cfg_wdata;
          default:         ;
        endcase
      end

      // input word: update state, queue a hash on the last byte or empty message
      if (in_valid && !in_stall) begin
        if (in_empty_message) begin
          seed_state(31'd0);
          expected_hashes.push_back(finished_hash());
        end else begin
          if (in_first_of_message) seed_state(in_message_length);
          mix_byte(in_byte_value);
          if (in_last_of_message) expected_hashes.push_back(finished_hash());
        end
      end
    end
    hashes_owed = expected_hashes.size();
  end

endmodule

// ----- tb/multi_algorithm_string_hash_tb.sv -----
module multi_algorithm_string_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import shs_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_WORDS = 800;
  localparam int PHASE_WORDS  = 60;
  localparam int SETTLE       = 4;        // cycles for a word still in flight
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SEL_MAX      = 15;       // largest 4-bit selector
  localparam int TIMEOUT_NS   = 10_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'd0;
  logic        in_first_of_message = 1'b0;
  logic        in_last_of_message = 1'b0;
  logic        in_empty_message = 1'b0;
  logic [30:0] in_message_length = 31'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ALG_SELECT;
  logic [31:0] cfg_wdata = 32'd0;

  int mismatch_count;
  int hashes_owed;
  int words_sent = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  logic out_took = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  multi_algorithm_string_hash i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_first_of_message (in_first_of_message),
    .in_last_of_message  (in_last_of_message),
    .in_empty_message    (in_empty_message),
    .in_message_length   (in_message_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hash_value      (out_hash_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  string_hash_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_first_of_message (in_first_of_message),
    .in_last_of_message  (in_last_of_message),
    .in_empty_message    (in_empty_message),
    .in_message_length   (in_message_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hash_value      (out_hash_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatch_count),
    .hashes_owed         (hashes_owed)
  );

  // Receiver: after each hash word, may raise out_stall at random; never when no_idle is set
  always @(posedge clk) out_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (out_took) stall_left = no_idle ? 0 : $urandom_range(0, 3);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Byte values leaning toward the sign boundary and the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // One input word; called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [7:0] b, input logic is_first, input logic is_last,
                           input logic is_empty, input logic [30:0] len);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_byte_value       <= b;
    in_first_of_message <= is_first;
    in_last_of_message  <= is_last;
    in_empty_message    <= is_empty;
    in_message_length   <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Hold the input until every hash is out and the pipeline has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (hashes_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Well-formed message, or a burst of words with random flags
  task automatic send_message(input int n, input bit clean);
    logic [30:0] len;
    len = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'(n);
    for (int i = 0; i < n; i++) begin
      if (clean)
        send_word(pick_byte(), i == 0, i == n - 1, 1'b0, len);
      else
        send_word(pick_byte(), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 7) == 0, 31'($urandom));
    end
  endtask

  initial begin
    alg_t a;
    int   phase_end;
    int   guard;
    logic [31:0] mult;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // no start word after reset: continues from the reset state
    send_word(8'h80, 1'b0, 1'b1, 1'b0, 31'd0);

    // every algorithm, one-byte message, byte and length extremes
    a = a.first();
    for (int k = 0; k < a.num(); k++) begin
      write_reg(CFG_ALG_SELECT, 32'(a));
      send_word(k[0] ? 8'h80 : 8'hFF, 1'b1, 1'b1, 1'b0, k[0] ? 31'h7FFF_FFFF : 31'd0);
      a = a.next();
    end

    // AP alternates its mix on odd and even bytes
    write_reg(CFG_ALG_SELECT, 32'(ALG_AP));
    send_word(8'h00, 1'b1, 1'b0, 1'b0, 31'd3);
    send_word(8'h7F, 1'b0, 1'b0, 1'b0, 31'd3);
    send_word(8'hFF, 1'b0, 1'b1, 1'b0, 31'd3);

    // empty messages: seed ignores length and flags
    write_reg(CFG_ALG_SELECT, 32'(ALG_DEK));
    send_word(8'hA5, 1'b0, 1'b0, 1'b1, 31'h7FFF_FFFF);
    write_reg(CFG_ALG_SELECT, 32'(ALG_CRC));
    send_word(8'h5A, 1'b1, 1'b1, 1'b1, 31'd0);

    // zero-extended bytes with BKDR multiplier extremes
    write_reg(CFG_BYTE_SIGNED, 32'd0);
    write_reg(CFG_ALG_SELECT, 32'(ALG_BKDR));
    write_reg(CFG_BKDR_MULT, 32'd0);
    send_word(8'hFF, 1'b1, 1'b1, 1'b0, 31'd1);
    write_reg(CFG_BKDR_MULT, 32'hFFFF_FFFF);
    send_word(8'hFF, 1'b1, 1'b0, 1'b0, 31'd2);
    send_word(8'h01, 1'b0, 1'b1, 1'b0, 31'd2);

    // unused selector
    write_reg(CFG_ALG_SELECT, 32'($urandom_range(int'(ALG_CRC) + 1, SEL_MAX)));
    send_word(8'h33, 1'b1, 1'b0, 1'b0, 31'd2);
    send_word(8'hCC, 1'b0, 1'b1, 1'b0, 31'd2);

    // algorithm switched in the middle of a message
    write_reg(CFG_BYTE_SIGNED, 32'd1);
    write_reg(CFG_ALG_SELECT, 32'(ALG_DJB));
    send_word(8'h41, 1'b1, 1'b0, 1'b0, 31'd2);
    write_reg(CFG_ALG_SELECT, 32'(ALG_SDBM));
    send_word(8'hC3, 1'b0, 1'b1, 1'b0, 31'd2);

    // random phases, each under a fresh configuration
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 6) == 0)
        write_reg(CFG_ALG_SELECT, 32'($urandom_range(int'(ALG_CRC) + 1, SEL_MAX)));
      else
        write_reg(CFG_ALG_SELECT, 32'($urandom_range(ALG_RS, ALG_CRC)));
      write_reg(CFG_BYTE_SIGNED, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0:       mult = 32'd0;
        1:       mult = 32'hFFFF_FFFF;
        2:       mult = BKDR_INIT;
        default: mult = $urandom;
      endcase
      write_reg(CFG_BKDR_MULT, mult);
      no_idle = ($urandom_range(0, 3) == 0);

      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end && words_sent < RANDOM_WORDS) begin
        case ($urandom_range(0, 19))
          0, 1:    send_message($urandom_range(1, 6), 1'b0);
          2:       send_word(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'b1, 31'($urandom));
          3:       send_message($urandom_range(17, 40), 1'b1);
          default: send_message($urandom_range(1, 16), 1'b1);
        endcase
        // sender holds off until the block has emptied
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end

    // wait for the last hashes, then let the pipeline settle
    in_valid <= 1'b0;
    guard = 0;
    while (hashes_owed != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE) @(negedge clk);

    if (mismatch_count == 0 && hashes_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/shs_pkg.sv
rtl/shs_absorb.sv
rtl/shs_out_reg.sv
rtl/multi_algorithm_string_hash.sv
tb/string_hash_checker.sv
tb/multi_algorithm_string_hash_tb.sv
